// ===== rtl/core/bcknf_pkg.sv =====
package bcknf_pkg;

    // Frame limits
    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 16384;

    // Field and counter widths
    localparam int PIX_W    = 24;
    localparam int CHAN_W   = 8;
    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int ROW_W    = $clog2(MAX_HEIGHT + 2);
    localparam int WIDTH_W  = 12;
    localparam int HEIGHT_W = 15;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

    // Register reset values
    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 12'd640;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 15'd480;

    localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;
    localparam logic [CHAN_W-1:0] ALPHA_KEYED  = 8'h00;

    // Position of the pixel that leaves with a transaction, and which of
    // its neighbors lie inside the frame
    typedef struct packed {
        logic             res_valid;
        logic             last;
        logic             has_up;
        logic             has_down;
        logic             has_left;
        logic             has_right;
        logic [COL_W-1:0] col;
    } pos_info_t;

endpackage

// ===== rtl/core/bcknf_position.sv =====
module bcknf_position import bcknf_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_accept,
    output pos_info_t             pos,
    output logic                  restart
);

    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [COL_W-1:0]    col_reg, col_next;
    logic [ROW_W-1:0]    row_reg, row_next;
    logic [WIDTH_W-1:0]  w_eff;
    logic [ROW_W-1:0]    h_eff;
    logic                col_zero;
    logic                row_wrap;

    assign cfg_ready = 1'b1;
    assign restart   = cfg_valid && (cfg_index == REG_IMAGE_WIDTH ||
                                     cfg_index == REG_IMAGE_HEIGHT);

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end else if (cfg_valid) begin
            if (cfg_index == REG_IMAGE_WIDTH) begin
                width_reg <= cfg_data[WIDTH_W-1:0];
            end
            if (cfg_index == REG_IMAGE_HEIGHT) begin
                height_reg <= cfg_data[HEIGHT_W-1:0];
            end
        end
    end

    // Effective frame size: zero acts as one, clamp to the maxima
    always_comb begin
        priority if (width_reg == '0) begin
            w_eff = WIDTH_W'(1);
        end else if (width_reg > WIDTH_W'(MAX_WIDTH)) begin
            w_eff = WIDTH_W'(MAX_WIDTH);
        end else begin
            w_eff = width_reg;
        end
        priority if (height_reg == '0) begin
            h_eff = ROW_W'(1);
        end else if (height_reg > HEIGHT_W'(MAX_HEIGHT)) begin
            h_eff = ROW_W'(MAX_HEIGHT);
        end else begin
            h_eff = ROW_W'(height_reg);
        end
    end

    // Output pixel trails the input by one row plus one pixel
    assign col_zero = (col_reg == '0);
    always_comb begin
        pos.col = col_reg;
        if (!col_zero) begin
            pos.res_valid = (row_reg >= ROW_W'(1)) && (row_reg <= h_eff);
            pos.has_up    = (row_reg >= ROW_W'(2));
            pos.has_down  = (row_reg < h_eff);
            pos.has_left  = (col_reg >= COL_W'(2));
            pos.has_right = 1'b1;
            pos.last      = 1'b0;
        end else begin
            pos.res_valid = (row_reg >= ROW_W'(2)) && (row_reg <= h_eff + ROW_W'(1));
            pos.has_up    = (row_reg >= ROW_W'(3));
            pos.has_down  = (row_reg <= h_eff);
            pos.has_left  = (w_eff > WIDTH_W'(1));
            pos.has_right = 1'b0;
            pos.last      = (row_reg == h_eff + ROW_W'(1));
        end
    end

    // Raster counters, cleared after the last pixel of a frame and on restart
    assign row_wrap = ({1'b0, col_reg} + WIDTH_W'(1)) >= w_eff;
    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (restart) begin
            col_next = '0;
            row_next = '0;
        end else if (in_accept) begin
            priority if (pos.last) begin
                col_next = '0;
                row_next = '0;
            end else if (row_wrap) begin
                col_next = '0;
                row_next = row_reg + ROW_W'(1);
            end else begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

// ===== rtl/core/bcknf_line_buffer.sv =====
module bcknf_line_buffer import bcknf_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             rd_en,
    input  logic [COL_W-1:0] rd_addr,
    input  logic             wr_en,
    input  logic [COL_W-1:0] wr_addr,
    input  logic [PIX_W-1:0] wr_pix,
    output logic [PIX_W-1:0] up_pix,
    output logic [PIX_W-1:0] mid_pix
);

    logic [PIX_W-1:0] upper_mem [MAX_WIDTH];
    logic [PIX_W-1:0] middle_mem [MAX_WIDTH];
    logic [PIX_W-1:0] up_rd_reg;
    logic [PIX_W-1:0] mid_rd_reg;
    logic             fwd_reg;
    logic [PIX_W-1:0] fwd_up_reg;
    logic [PIX_W-1:0] fwd_mid_reg;

    // Rows move down one line: middle row goes to upper, new pixel to middle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            upper_mem[wr_addr]  <= mid_pix;
            middle_mem[wr_addr] <= wr_pix;
        end
        if (rd_en) begin
            up_rd_reg  <= upper_mem[rd_addr];
            mid_rd_reg <= middle_mem[rd_addr];
        end
    end

    // Bypass for a read that hits the column being written (one-pixel rows)
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_reg <= 1'b0;
        end else if (rd_en) begin
            fwd_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            fwd_up_reg  <= mid_pix;
            fwd_mid_reg <= wr_pix;
        end
    end

    assign up_pix  = fwd_reg ? fwd_up_reg  : up_rd_reg;
    assign mid_pix = fwd_reg ? fwd_mid_reg : mid_rd_reg;

endmodule

// ===== rtl/core/bcknf_fill.sv =====
module bcknf_fill import bcknf_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             restart,
    // Item entering the pipeline
    input  logic             in_accept,
    output logic             in_ready,
    input  logic [PIX_W-1:0] in_pix,
    input  pos_info_t        in_pos,
    // Line buffer
    input  logic [PIX_W-1:0] up_pix,
    input  logic [PIX_W-1:0] mid_pix,
    output logic             wr_en,
    output logic [COL_W-1:0] wr_addr,
    output logic [PIX_W-1:0] wr_pix,
    // Result register
    output logic             out_valid,
    input  logic             out_ready,
    output logic [PIX_W-1:0] out_color,
    output logic [CHAN_W-1:0] out_alpha,
    output logic             out_last,
    output logic             out_black
);

    logic             s1_valid_reg;
    pos_info_t        pos_reg;
    logic [PIX_W-1:0] pix_reg;
    logic             s1_fire;
    logic             emit;

    // Window columns: 1 = left column, 2 = center column (up, mid, down)
    logic [PIX_W-1:0] w1_up_reg, w1_mid_reg, w1_dn_reg;
    logic [PIX_W-1:0] w2_up_reg, w2_mid_reg, w2_dn_reg;
    logic             black_seen_reg, black_seen_next;

    logic [PIX_W-1:0] center;
    logic [PIX_W-1:0] fill_color;
    logic [PIX_W-1:0] color_next;
    logic             keyed;

    logic             out_valid_reg;
    logic [PIX_W-1:0] out_color_reg;
    logic [CHAN_W-1:0] out_alpha_reg;
    logic             out_last_reg;
    logic             out_black_reg;

    // Stage advances unless its result would overwrite one still waiting
    assign s1_fire  = s1_valid_reg && (!pos_reg.res_valid || !out_valid_reg || out_ready);
    assign emit     = s1_fire && pos_reg.res_valid;
    assign in_ready = !s1_valid_reg || s1_fire;

    assign wr_en   = s1_fire;
    assign wr_addr = pos_reg.col;
    assign wr_pix  = pix_reg;

    // Input stage register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (in_accept) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_fire) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            pos_reg <= in_pos;
            pix_reg <= in_pix;
        end
    end

    // Neighbor pick: up, right, down, left, then the corners
    assign center = w2_mid_reg;
    assign keyed  = (center == '0);
    always_comb begin
        priority if (pos_reg.has_up && w2_up_reg != '0) begin
            fill_color = w2_up_reg;
        end else if (pos_reg.has_right && mid_pix != '0) begin
            fill_color = mid_pix;
        end else if (pos_reg.has_down && w2_dn_reg != '0) begin
            fill_color = w2_dn_reg;
        end else if (pos_reg.has_left && w1_mid_reg != '0) begin
            fill_color = w1_mid_reg;
        end else if (pos_reg.has_up && pos_reg.has_left && w1_up_reg != '0) begin
            fill_color = w1_up_reg;
        end else if (pos_reg.has_up && pos_reg.has_right && up_pix != '0) begin
            fill_color = up_pix;
        end else if (pos_reg.has_down && pos_reg.has_right && pix_reg != '0) begin
            fill_color = pix_reg;
        end else if (pos_reg.has_down && pos_reg.has_left && w1_dn_reg != '0) begin
            fill_color = w1_dn_reg;
        end else begin
            fill_color = '0;
        end
    end

    assign color_next = keyed ? fill_color : center;

    // Sticky black flag, current pixel included
    always_comb begin
        black_seen_next = black_seen_reg;
        if (restart) begin
            black_seen_next = 1'b0;
        end else if (emit) begin
            black_seen_next = (black_seen_reg || keyed) && !pos_reg.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            black_seen_reg <= 1'b0;
        end else begin
            black_seen_reg <= black_seen_next;
        end
    end

    // Window shift; cleared at frame end and on restart
    always_ff @(posedge aclk) begin
        if (!aresetn || restart || (emit && pos_reg.last)) begin
            w1_up_reg  <= '0;
            w1_mid_reg <= '0;
            w1_dn_reg  <= '0;
            w2_up_reg  <= '0;
            w2_mid_reg <= '0;
            w2_dn_reg  <= '0;
        end else if (s1_fire) begin
            w1_up_reg  <= w2_up_reg;
            w1_mid_reg <= w2_mid_reg;
            w1_dn_reg  <= w2_dn_reg;
            w2_up_reg  <= up_pix;
            w2_mid_reg <= mid_pix;
            w2_dn_reg  <= pix_reg;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (emit) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            out_color_reg <= color_next;
            out_alpha_reg <= keyed ? ALPHA_KEYED : ALPHA_OPAQUE;
            out_last_reg  <= pos_reg.last;
            out_black_reg <= black_seen_reg || keyed;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_color = out_color_reg;
    assign out_alpha = out_alpha_reg;
    assign out_last  = out_last_reg;
    assign out_black = out_black_reg;

endmodule

// ===== rtl/core/black_color_key_neighbor_fill_core.sv =====
// Black color key with neighbor fill. Takes RGB pixels in raster order, one
// per cycle, and returns RGBA pixels: a non-black pixel passes with alpha 255,
// a pure black one gets alpha 0 and the color of its first non-black
// in-frame neighbor (up, right, down, left, upper-left, upper-right,
// lower-right, lower-left), or stays black. A 3x3 window fed by two
// 2048 x 24 bit line buffers gives a sustained rate of one pixel per cycle
// while m_tready holds; each result leaves on the transaction that brings the
// input one row plus one pixel later, then passes the line buffer read and the
// result register, so after each frame the source sends image_width + 1 items with
// the padding flag set. m_tlast marks the last pixel, m_tuser is the sticky
// black-seen flag of the frame. Writing image_width or image_height restarts
// the frame; do it only while the block is idle. Line buffers are not
// cleared after reset and need no clearing pass.
module black_color_key_neighbor_fill_core import bcknf_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // Input pixels
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [23:0]           s_tdata,   // red[7:0], green[15:8], blue[23:16]
    input  logic                  s_tuser,   // padding
    // Output pixels
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [31:0]           m_tdata,   // out_red[7:0], out_green[15:8],
                                             // out_blue[23:16], out_alpha[31:24]
    output logic                  m_tlast,   // last_pixel
    output logic                  m_tuser    // any_black
);

    logic             in_accept;
    logic             restart;
    pos_info_t        pos;
    logic [PIX_W-1:0] in_pix;
    logic [PIX_W-1:0] up_pix, mid_pix;
    logic             wr_en;
    logic [COL_W-1:0] wr_addr;
    logic [PIX_W-1:0] wr_pix;
    logic [PIX_W-1:0] out_color;
    logic [CHAN_W-1:0] out_alpha;

    assign in_accept = s_tvalid && s_tready;

    // Internal color word is red:green:blue from the top; padding reads black
    assign in_pix = s_tuser ? '0 : {s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]};

    bcknf_position u_position (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_accept (in_accept),
        .pos       (pos),
        .restart   (restart)
    );

    bcknf_line_buffer u_line_buffer (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (in_accept),
        .rd_addr (pos.col),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_pix  (wr_pix),
        .up_pix  (up_pix),
        .mid_pix (mid_pix)
    );

    bcknf_fill u_fill (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .restart   (restart),
        .in_accept (in_accept),
        .in_ready  (s_tready),
        .in_pix    (in_pix),
        .in_pos    (pos),
        .up_pix    (up_pix),
        .mid_pix   (mid_pix),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_pix    (wr_pix),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_color (out_color),
        .out_alpha (out_alpha),
        .out_last  (m_tlast),
        .out_black (m_tuser)
    );

    assign m_tdata = {out_alpha, out_color[7:0], out_color[15:8], out_color[23:16]};

    // A keyed pixel always reports black seen
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[31:24] == ALPHA_KEYED |-> m_tuser)
        else $error("keyed pixel without black flag");

    // Alpha is either keyed or opaque
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[31:24] == ALPHA_KEYED || m_tdata[31:24] == ALPHA_OPAQUE))
        else $error("alpha neither keyed nor opaque");

    // An opaque pixel is never black
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[31:24] == ALPHA_OPAQUE |-> m_tdata[23:0] != '0)
        else $error("opaque pixel is black");

    // An idle result register never blocks input
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

endmodule
